/* src/lgge_pkg.sv */
// Shared types, codes and cell-rule functions for the life grid generation engine.
// No dependencies; lgge_row_eval, lgge_seq, the top level and the checker import this package.
`default_nettype none

package lgge_pkg;

  localparam int CMD_W       = 2;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 6;
  localparam int COUNT_W     = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int GRID_WIDTH_W  = 8;
  localparam int GRID_HEIGHT_W = 7;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 8'd80;
  localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 7'd25;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT    = 4'd3;
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT  = 4'd2;
  localparam logic [COUNT_W-1:0] MAX_NEIGHBOURS = 4'd8;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             alive;
  } in_item_t;

  typedef struct packed {
    logic               cell_alive;
    logic [COUNT_W-1:0] neighbour_count;
    logic               status;
  } out_item_t;

  // Each argument holds the left, center and right cells of one row.
  function automatic logic [COUNT_W-1:0] nb_count(input logic [2:0] above,
                                                  input logic [2:0] level,
                                                  input logic [2:0] below);
    return COUNT_W'(above[0]) + COUNT_W'(above[1]) + COUNT_W'(above[2]) +
           COUNT_W'(level[0]) + COUNT_W'(level[2]) +
           COUNT_W'(below[0]) + COUNT_W'(below[1]) + COUNT_W'(below[2]);
  endfunction

  function automatic logic next_state(input logic self, input logic [COUNT_W-1:0] count);
    return (count == BIRTH_COUNT) || (self && (count == SURVIVE_COUNT));
  endfunction

endpackage

`default_nettype wire

/* src/lgge_stream_if.sv */
// Valid/ready channel interface carrying one payload of a given type.
// No dependencies.
`default_nettype none

interface lgge_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/lgge_row_eval.sv */
// Next-generation evaluation of one full grid row from the rows above, at and below it.
// Depends on lgge_pkg.
`default_nettype none

module lgge_row_eval import lgge_pkg::*; #(
  parameter int MAX_COLS = 128
) (
  input  logic [MAX_COLS-1:0] above,
  input  logic [MAX_COLS-1:0] level,
  input  logic [MAX_COLS-1:0] below,
  output logic [MAX_COLS-1:0] next_row
);

  logic [MAX_COLS+1:0] pad_above;
  logic [MAX_COLS+1:0] pad_level;
  logic [MAX_COLS+1:0] pad_below;

  assign pad_above = {1'b0, above, 1'b0};
  assign pad_level = {1'b0, level, 1'b0};
  assign pad_below = {1'b0, below, 1'b0};

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      next_row[c] = next_state(pad_level[c+1],
                               nb_count(pad_above[c +: 3], pad_level[c +: 3],
                                        pad_below[c +: 3]));
    end
  end

endmodule

`default_nettype wire

/* src/lgge_plane_mem.sv */
// Row-wide cell memory holding both grid planes, one write and one registered read port.
// No dependencies.
`default_nettype none

module lgge_plane_mem #(
  parameter int ADDR_W = 7,
  parameter int WORD_W = 128
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* src/lgge_seq.sv */
// Command sequencer: clearing pass, cell read/write and whole-grid advance over the memory.
// Depends on lgge_pkg, lgge_stream_if and lgge_row_eval.
`default_nettype none

module lgge_seq import lgge_pkg::*; #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [GRID_WIDTH_W-1:0]                    grid_width,
  input  logic [GRID_HEIGHT_W-1:0]                   grid_height,
  lgge_stream_if.sink                                in_item,
  lgge_stream_if.source                              out_item,
  output logic                                       mem_wr_en,
  output logic [$clog2(MAX_ROWS):0]                  mem_wr_addr,
  output logic [MAX_COLS-1:0]                        mem_wr_data,
  output logic [$clog2(MAX_ROWS):0]                  mem_rd_addr,
  input  logic [MAX_COLS-1:0]                        mem_rd_data
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int AW  = RW + 1;
  localparam int CW  = $clog2(MAX_COLS);
  localparam int PW  = $clog2(MAX_COLS + 2);
  localparam int KW  = $clog2(MAX_ROWS + 1);
  localparam int ACW = $clog2(MAX_COLS + 1);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_WR_ISS   = 11'b000_0000_0100,
    S_WR_MOD   = 11'b000_0000_1000,
    S_RD_ISS   = 11'b000_0001_0000,
    S_RD_WAIT  = 11'b000_0010_0000,
    S_RD_CNT   = 11'b000_0100_0000,
    S_ADV      = 11'b000_1000_0000,
    S_ADV_RET  = 11'b001_0000_0000,
    S_ADV_EVAL = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  logic                plane;
  in_item_t            req;
  logic [1:0]          rd_step;
  logic [KW-1:0]       k;
  logic                ret_valid;
  logic                ret_ok;
  logic                ret_adv;
  logic [KW-1:0]       ret_k;
  logic                ev_valid;
  logic [KW-1:0]       ev_k;
  logic [MAX_COLS-1:0] win_above;
  logic [MAX_COLS-1:0] win_level;
  logic [MAX_COLS-1:0] win_below;
  out_item_t           res;
  out_item_t           out_data;
  logic                out_valid;

  logic [ACW-1:0]      act_cols;
  logic [KW-1:0]       act_rows;
  logic [MAX_COLS-1:0] col_mask;
  logic                in_accept;
  logic                in_inside;
  logic                in_status;
  logic [ROW_W:0]      rd_idx;
  logic                rd_ok;
  logic                iss_en;
  logic                iss_ok;
  logic [MAX_COLS-1:0] next_row;
  logic                dst_ok;
  logic [MAX_COLS-1:0] wr_word;
  logic [MAX_COLS+1:0] pad_above;
  logic [MAX_COLS+1:0] pad_level;
  logic [MAX_COLS+1:0] pad_below;
  logic [PW-1:0]       col_base;
  logic [COUNT_W-1:0]  rd_count;
  logic                out_free;

  assign act_cols = (int'(grid_width) > MAX_COLS) ? ACW'(MAX_COLS) : ACW'(grid_width);
  assign act_rows = (int'(grid_height) > MAX_ROWS) ? KW'(MAX_ROWS) : KW'(grid_height);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(act_cols));
    end
  end

  assign in_accept = in_item.valid && in_item.ready;
  assign in_inside = (int'(in_item.payload.col) < int'(act_cols)) &&
                     (int'(in_item.payload.row) < int'(act_rows));
  assign in_status = (((in_item.payload.cmd == CMD_WRITE) ||
                       (in_item.payload.cmd == CMD_READ)) && !in_inside) ?
                     STATUS_OUTSIDE : STATUS_OK;

  // rd_idx is the addressed row plus one, so the row above row zero is index zero.
  assign rd_idx = {1'b0, req.row} + {{(ROW_W-1){1'b0}}, rd_step};
  assign rd_ok  = (rd_idx != '0) && (int'(rd_idx) <= int'(act_rows));

  assign iss_en = (state == S_RD_ISS) || (state == S_WR_ISS) || (state == S_ADV);

  always_comb begin
    iss_ok      = 1'b0;
    mem_rd_addr = {plane, RW'(req.row)};
    unique case (state)
      S_RD_ISS: begin
        iss_ok      = rd_ok;
        mem_rd_addr = {plane, RW'(rd_idx - 1'b1)};
      end
      S_ADV: begin
        iss_ok      = (k < act_rows);
        mem_rd_addr = {plane, RW'(k)};
      end
      default: begin
      end
    endcase
  end

  lgge_row_eval #(
    .MAX_COLS (MAX_COLS)
  ) u_row_eval (
    .above    (win_above),
    .level    (win_level),
    .below    (win_below),
    .next_row (next_row)
  );

  assign dst_ok = (ev_k <= act_rows);

  always_comb begin
    wr_word                = mem_rd_data;
    wr_word[CW'(req.col)]  = req.alive;
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = '0;
    priority if (state == S_CLEAR) begin
      mem_wr_en = 1'b1;
    end else if (state == S_WR_MOD) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = {plane, RW'(req.row)};
      mem_wr_data = wr_word;
    end else if (ev_valid && (ev_k != '0)) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = {~plane, RW'(ev_k - 1'b1)};
      mem_wr_data = dst_ok ? (next_row & col_mask) : '0;
    end else begin
      mem_wr_en = 1'b0;
    end
  end

  assign pad_above = {1'b0, win_above, 1'b0};
  assign pad_level = {1'b0, win_level, 1'b0};
  assign pad_below = {1'b0, win_below, 1'b0};
  assign col_base  = PW'(req.col);
  assign rd_count  = nb_count(pad_above[col_base +: 3], pad_level[col_base +: 3],
                              pad_below[col_base +: 3]);

  assign out_free = !out_valid || out_item.ready;

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      win_above <= '0;
      win_level <= '0;
      win_below <= '0;
    end else if (ret_valid) begin
      win_above <= win_level;
      win_level <= win_below;
      win_below <= ret_ok ? (mem_rd_data & col_mask) : '0;
    end
    ret_ok <= iss_ok;
    ret_adv <= (state == S_ADV);
    ret_k <= k;
    ev_k <= ret_k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      plane     <= 1'b0;
      rd_step   <= '0;
      k         <= '0;
      ret_valid <= 1'b0;
      ev_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      ret_valid <= iss_en;
      ev_valid  <= ret_valid && ret_adv;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            req     <= in_item.payload;
            res     <= '{cell_alive: 1'b0, neighbour_count: '0, status: in_status};
            rd_step <= '0;
            k       <= '0;
            unique case (in_item.payload.cmd)
              CMD_WRITE: begin
                if (in_inside) begin
                  state <= S_WR_ISS;
                end else begin
                  state <= S_FINISH;
                end
              end
              CMD_READ: begin
                if (in_inside) begin
                  state <= S_RD_ISS;
                end else begin
                  state <= S_FINISH;
                end
              end
              CMD_ADVANCE: begin
                state <= S_ADV;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_WR_ISS: begin
          state <= S_WR_MOD;
        end
        S_WR_MOD: begin
          state <= S_FINISH;
        end
        S_RD_ISS: begin
          rd_step <= rd_step + 1'b1;
          if (rd_step == 2'd2) begin
            state <= S_RD_WAIT;
          end
        end
        S_RD_WAIT: begin
          state <= S_RD_CNT;
        end
        S_RD_CNT: begin
          res.cell_alive      <= win_level[CW'(req.col)];
          res.neighbour_count <= rd_count;
          res.status          <= STATUS_OK;
          state               <= S_FINISH;
        end
        S_ADV: begin
          k <= k + 1'b1;
          if (k == KW'(MAX_ROWS)) begin
            state <= S_ADV_RET;
          end
        end
        S_ADV_RET: begin
          state <= S_ADV_EVAL;
        end
        S_ADV_EVAL: begin
          plane <= ~plane;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_item.ready    = (state == S_IDLE);
  assign out_item.valid   = out_valid;
  assign out_item.payload = out_data;

endmodule

`default_nettype wire

/* src/life_grid_generation_engine_core.sv */
// Top level of the life grid generation engine: configuration registers, memory, sequencer.
// Depends on lgge_pkg, lgge_stream_if, lgge_plane_mem and lgge_seq.
//
//   Channel   Direction  Handshake             Payload
//   in_item   sink       valid/ready           cmd, col, row, alive
//   out_item  source     valid/ready           cell_alive, neighbour_count, status
//   cfg       write      cfg_wr_en, no ready   cfg_index, cfg_data
//
// A write reads and rewrites the addressed row, a read fetches the rows above, at and below
// the cell, and an advance reads the current plane row by row, all through the single read
// port of the plane memory. After reset a clearing pass over both planes runs before the
// first transaction is taken. A stalled result is held in the output register while the
// next transaction is accepted; only its completion waits for the register to drain.
`default_nettype none

module life_grid_generation_engine_core import lgge_pkg::*; #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lgge_stream_if.sink           in_item,
  lgge_stream_if.source         out_item
);

  localparam int AW = $clog2(MAX_ROWS) + 1;

  logic [GRID_WIDTH_W-1:0]  grid_width;
  logic [GRID_HEIGHT_W-1:0] grid_height;
  logic                     mem_wr_en;
  logic [AW-1:0]            mem_wr_addr;
  logic [MAX_COLS-1:0]      mem_wr_data;
  logic [AW-1:0]            mem_rd_addr;
  logic [MAX_COLS-1:0]      mem_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data[GRID_HEIGHT_W-1:0];
      endcase
    end
  end

  lgge_plane_mem #(
    .ADDR_W (AW),
    .WORD_W (MAX_COLS)
  ) u_plane_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  lgge_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .in_item     (in_item),
    .out_item    (out_item),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

/* src/lgge_checker.sv */
// Port-level assertions for the life grid generation engine, bound to its top level.
// Depends on lgge_pkg and life_grid_generation_engine_core.
`default_nettype none

module lgge_checker import lgge_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_cell_alive,
  input logic [COUNT_W-1:0] out_count,
  input logic               out_status
);

  // A result that is not taken stays on offer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transaction completed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= MAX_NEIGHBOURS)
    else $error("neighbour count above eight");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == STATUS_OUTSIDE) |-> !out_cell_alive && (out_count == '0))
    else $error("out-of-grid result carries cell data");

  // Every command occupies the engine in the cycle after it is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

endmodule

bind life_grid_generation_engine_core lgge_checker u_lgge_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_item.valid),
  .in_ready       (in_item.ready),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .out_cell_alive (out_item.payload.cell_alive),
  .out_count      (out_item.payload.neighbour_count),
  .out_status     (out_item.payload.status)
);

`default_nettype wire
